### rtl/core/nbt_pkg.sv
package nbt_pkg;

  localparam int unsigned MaxTracks = 16;
  localparam int unsigned MaxBlobs  = 16;
  localparam int unsigned SlotW     = $clog2(MaxTracks);
  localparam int unsigned BlobW     = $clog2(MaxBlobs);
  localparam int unsigned BcntW     = $clog2(MaxBlobs + 1);

  localparam logic [11:0] RadiusReset = 12'd100;
  localparam logic [15:0] GainReset   = 16'd655;

  typedef enum logic [1:0] {
    OC_EMPTY   = 2'd0,
    OC_MATCHED = 2'd1,
    OC_NEW     = 2'd2,
    OC_DROPPED = 2'd3
  } outcome_t;

  typedef enum logic {
    CFG_RADIUS = 1'b0,
    CFG_GAIN   = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SMX,
    ST_SMY,
    ST_UPD,
    ST_FREE,
    ST_EMIT,
    ST_EMPTY,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_blob;   // capture input beat, start a slot scan
    logic scan_step;   // compare one slot
    logic sm_x;        // smoothing multiply x
    logic sm_y;        // smoothing multiply y
    logic upd;         // record the blob and its match in the frame buffer
    logic free_dead;   // release unclaimed slots
    logic emit_load;   // form one result
    logic empty_load;  // form empty frame result
    logic frame_done;  // clear claims and count
  } nbt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic found;
    logic emit_last;
    logic has_blobs;
    logic take_blob;
  } nbt_sts_t;

endpackage

### rtl/core/nbt_ctrl.sv
module nbt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_frame_end,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  nbt_pkg::nbt_sts_t sts,
  output nbt_pkg::nbt_cmd_t cmd
);

  nbt_pkg::state_t state_r, state_nxt;
  logic fend_r, fend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nbt_pkg::ST_IDLE;
      fend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fend_r  <= fend_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fend_nxt  = fend_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      nbt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_blob = 1'b1;
          fend_nxt      = in_frame_end;
          if (sts.take_blob) state_nxt = nbt_pkg::ST_SCAN;
          else if (in_frame_end) state_nxt = nbt_pkg::ST_FREE;
        end
      end
      nbt_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          if (sts.found) state_nxt = nbt_pkg::ST_SMX;
          else state_nxt = nbt_pkg::ST_UPD;
        end
      end
      nbt_pkg::ST_SMX: begin
        cmd.sm_x  = 1'b1;
        state_nxt = nbt_pkg::ST_SMY;
      end
      nbt_pkg::ST_SMY: begin
        cmd.sm_y  = 1'b1;
        state_nxt = nbt_pkg::ST_UPD;
      end
      nbt_pkg::ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = fend_r ? nbt_pkg::ST_FREE : nbt_pkg::ST_IDLE;
      end
      nbt_pkg::ST_FREE: begin
        cmd.free_dead = 1'b1;
        state_nxt = sts.has_blobs ? nbt_pkg::ST_EMIT : nbt_pkg::ST_EMPTY;
      end
      nbt_pkg::ST_EMIT: begin
        cmd.emit_load = 1'b1;
        state_nxt     = nbt_pkg::ST_OUT;
      end
      nbt_pkg::ST_EMPTY: begin
        cmd.empty_load = 1'b1;
        state_nxt      = nbt_pkg::ST_OUT;
      end
      nbt_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.emit_last) begin
            cmd.frame_done = 1'b1;
            state_nxt      = nbt_pkg::ST_IDLE;
          end else begin
            state_nxt = nbt_pkg::ST_EMIT;
          end
        end
      end
      default: state_nxt = nbt_pkg::ST_IDLE;
    endcase
  end

endmodule

### rtl/core/nbt_dp.sv
module nbt_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [0:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic [15:0]       in_blob_x,
  input  logic [15:0]       in_blob_y,
  input  logic              in_blob_present,
  input  nbt_pkg::nbt_cmd_t cmd,
  output nbt_pkg::nbt_sts_t sts,
  output logic [3:0]        out_blob_index,
  output logic [1:0]        out_outcome,
  output logic [15:0]       out_track_id,
  output logic [23:0]       out_smooth_x,
  output logic [23:0]       out_smooth_y,
  output logic [15:0]       out_age_frames,
  output logic              out_last
);

  localparam int unsigned NT = nbt_pkg::MaxTracks;
  localparam int unsigned NB = nbt_pkg::MaxBlobs;
  localparam int unsigned SW = nbt_pkg::SlotW;
  localparam int unsigned BW = nbt_pkg::BlobW;
  localparam int unsigned CW = nbt_pkg::BcntW;

  logic [11:0] radius_r;
  logic [15:0] gain_r;

  logic [NT-1:0] live_r, claimed_r;
  logic [15:0] id_r [NT];
  logic [15:0] px_r [NT];
  logic [15:0] py_r [NT];
  logic [23:0] sx_r [NT];
  logic [23:0] sy_r [NT];
  logic [15:0] age_r [NT];

  logic [15:0] bx_r [NB];
  logic [15:0] by_r [NB];
  logic        bm_r [NB];
  logic [SW-1:0] bs_r [NB];
  logic [CW-1:0] bcnt_r;
  logic [15:0]   next_id_r;

  logic [15:0] cx_r, cy_r;
  logic [SW-1:0] scan_r;
  logic found_r;
  logic [SW-1:0] best_r;
  logic [32:0] bestd_r;
  logic [23:0] smx_r;
  logic [BW-1:0] emit_r;

  // distance of the slot under scan
  logic [15:0] dx, dy;
  logic [32:0] d2, r2;
  logic [15:0] r16;
  logic hit, better;

  always_comb begin
    dx  = (px_r[scan_r] > cx_r) ? px_r[scan_r] - cx_r : cx_r - px_r[scan_r];
    dy  = (py_r[scan_r] > cy_r) ? py_r[scan_r] - cy_r : cy_r - py_r[scan_r];
    d2  = {1'b0, 32'(dx) * 32'(dx)} + {1'b0, 32'(dy) * 32'(dy)};
    r16 = {radius_r, 4'b0};
    r2  = {1'b0, 32'(r16) * 32'(r16)};
    hit = live_r[scan_r] && !claimed_r[scan_r] && (d2 < r2);
    better = !found_r || (d2 < bestd_r) ||
             ((d2 == bestd_r) && (id_r[scan_r] < id_r[best_r]));
  end

  // smoothing, one axis per cycle
  logic [23:0] sm_s;
  logic [15:0] sm_p;
  logic [40:0] sm_acc;
  always_comb begin
    sm_s   = cmd.sm_x ? sx_r[best_r] : sy_r[best_r];
    sm_p   = cmd.sm_x ? cx_r : cy_r;
    sm_acc = 41'(sm_s) * 41'(17'h10000 - 17'(gain_r))
           + 41'({sm_p, 8'b0}) * 41'(gain_r);
  end

  // lowest free slot for a new tracker
  logic [SW-1:0] free_slot;
  logic free_any;
  always_comb begin
    free_slot = '0;
    free_any  = 1'b0;
    for (int i = NT - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        free_slot = SW'(i);
        free_any  = 1'b1;
      end
    end
  end

  logic [CW-1:0] emit_ext;
  assign emit_ext = CW'(emit_r);

  assign sts.scan_last = (scan_r == SW'(NT - 1));
  assign sts.found     = found_r || hit;
  assign sts.emit_last = out_last;
  assign sts.has_blobs = (bcnt_r != '0);
  assign sts.take_blob = in_blob_present && (bcnt_r < CW'(NB));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= nbt_pkg::RadiusReset;
      gain_r    <= nbt_pkg::GainReset;
      live_r    <= '0;
      claimed_r <= '0;
      bcnt_r    <= '0;
      next_id_r <= '0;
      emit_r    <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (nbt_pkg::cfg_idx_t'(cfg_index))
          nbt_pkg::CFG_RADIUS: radius_r <= cfg_data[11:0];
          nbt_pkg::CFG_GAIN:   gain_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_blob) begin
        cx_r    <= in_blob_x;
        cy_r    <= in_blob_y;
        scan_r  <= '0;
        found_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (hit && better) begin
          found_r <= 1'b1;
          best_r  <= scan_r;
          bestd_r <= d2;
        end
        scan_r <= scan_r + SW'(1);
      end
      if (cmd.sm_x) smx_r <= sm_acc[39:16];
      if (cmd.sm_y) begin
        sx_r[best_r] <= smx_r;
        sy_r[best_r] <= sm_acc[39:16];
        px_r[best_r] <= cx_r;
        py_r[best_r] <= cy_r;
        if (age_r[best_r] != 16'hFFFF) age_r[best_r] <= age_r[best_r] + 16'd1;
        claimed_r[best_r] <= 1'b1;
      end
      if (cmd.upd) begin
        bx_r[bcnt_r[BW-1:0]] <= cx_r;
        by_r[bcnt_r[BW-1:0]] <= cy_r;
        bm_r[bcnt_r[BW-1:0]] <= found_r;
        bs_r[bcnt_r[BW-1:0]] <= best_r;
        bcnt_r <= bcnt_r + CW'(1);
      end
      if (cmd.free_dead) begin
        live_r <= live_r & claimed_r;
        emit_r <= '0;
      end
      if (cmd.emit_load) begin
        out_blob_index <= 4'(emit_r);
        out_last       <= (emit_ext + CW'(1) == bcnt_r);
        out_age_frames <= 16'd0;
        if (bm_r[emit_r]) begin
          out_outcome    <= nbt_pkg::OC_MATCHED;
          out_track_id   <= id_r[bs_r[emit_r]];
          out_smooth_x   <= sx_r[bs_r[emit_r]];
          out_smooth_y   <= sy_r[bs_r[emit_r]];
          out_age_frames <= age_r[bs_r[emit_r]];
        end else if (free_any) begin
          out_outcome         <= nbt_pkg::OC_NEW;
          out_track_id        <= next_id_r;
          out_smooth_x        <= {bx_r[emit_r], 8'b0};
          out_smooth_y        <= {by_r[emit_r], 8'b0};
          live_r[free_slot]   <= 1'b1;
          claimed_r[free_slot] <= 1'b1;
          id_r[free_slot]     <= next_id_r;
          px_r[free_slot]     <= bx_r[emit_r];
          py_r[free_slot]     <= by_r[emit_r];
          sx_r[free_slot]     <= {bx_r[emit_r], 8'b0};
          sy_r[free_slot]     <= {by_r[emit_r], 8'b0};
          age_r[free_slot]    <= 16'd0;
          next_id_r           <= next_id_r + 16'd1;
        end else begin
          out_outcome  <= nbt_pkg::OC_DROPPED;
          out_track_id <= 16'd0;
          out_smooth_x <= {bx_r[emit_r], 8'b0};
          out_smooth_y <= {by_r[emit_r], 8'b0};
        end
        emit_r <= emit_r + BW'(1);
      end
      if (cmd.empty_load) begin
        out_blob_index <= '0;
        out_outcome    <= nbt_pkg::OC_EMPTY;
        out_track_id   <= '0;
        out_smooth_x   <= '0;
        out_smooth_y   <= '0;
        out_age_frames <= '0;
        out_last       <= 1'b1;
      end
      if (cmd.frame_done) begin
        claimed_r <= '0;
        bcnt_r    <= '0;
      end
    end
  end

endmodule

### rtl/core/nearest_blob_tracker_core.sv
// Nearest-neighbour blob tracker. Blob centroids arrive one beat each (Q12.4);
// each is compared against all tracker slots one slot per cycle through the
// single shared distance unit, then a matched tracker is smoothed one axis
// at a time before write-back; a beat with no blob is taken without a scan,
// and no new beat is accepted until the block is through with the last one.
// The frame_end beat then frees stale trackers and emits one result beat per
// buffered blob, or one empty result when none was buffered, each held until
// out_ready. New trackers are allocated in blob order at emit time.
// Config writes (index 0 match_radius, index 1 smooth_gain) are always ready.
module nearest_blob_tracker_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_blob_x,
  input  logic [15:0] in_blob_y,
  input  logic        in_blob_present,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_blob_index,
  output logic [1:0]  out_outcome,
  output logic [15:0] out_track_id,
  output logic [23:0] out_smooth_x,
  output logic [23:0] out_smooth_y,
  output logic [15:0] out_age_frames,
  output logic        out_last
);

  nbt_pkg::nbt_cmd_t cmd;
  nbt_pkg::nbt_sts_t sts;

  // configuration never stalls
  assign cfg_ready = 1'b1;

  nbt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_frame_end, .in_ready,
    .out_valid, .out_ready, .sts, .cmd
  );

  nbt_dp u_dp (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
    .in_blob_x, .in_blob_y, .in_blob_present, .cmd, .sts,
    .out_blob_index, .out_outcome, .out_track_id, .out_smooth_x,
    .out_smooth_y, .out_age_frames, .out_last
  );

endmodule

### rtl/core/nbt_checker.sv
module nbt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_outcome,
  input logic       out_last
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during output");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == nbt_pkg::OC_EMPTY |-> out_last)
    else $error("empty not last");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_last))
    else $error("output dropped");

endmodule

bind nearest_blob_tracker_core nbt_checker u_chk (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_outcome, .out_last
);

### tb/testbench.sv
module testbench;

  // one input beat as offered to the block
  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        present;
    logic        fend;
  } blob_beat_t;

  // one result beat as the tracker should give it
  typedef struct {
    logic [3:0]        blob_index;
    nbt_pkg::outcome_t outcome;
    logic [15:0]       track_id;
    logic [23:0]       smooth_x;
    logic [23:0]       smooth_y;
    logic [15:0]       age_frames;
    logic              last;
  } track_result_t;

  // a blob held until its frame closes
  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        matched;
    int          slot;
  } held_blob_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = nbt_pkg::CFG_RADIUS;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_blob_x = '0;
  logic [15:0] in_blob_y = '0;
  logic        in_blob_present = 1'b0;
  logic        in_frame_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_blob_index;
  logic [1:0]  out_outcome;
  logic [15:0] out_track_id;
  logic [23:0] out_smooth_x;
  logic [23:0] out_smooth_y;
  logic [15:0] out_age_frames;
  logic        out_last;

  nearest_blob_tracker_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_blob_x       (in_blob_x),
    .in_blob_y       (in_blob_y),
    .in_blob_present (in_blob_present),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_blob_index  (out_blob_index),
    .out_outcome     (out_outcome),
    .out_track_id    (out_track_id),
    .out_smooth_x    (out_smooth_x),
    .out_smooth_y    (out_smooth_y),
    .out_age_frames  (out_age_frames),
    .out_last        (out_last)
  );

  always #1 clk = ~clk;

  blob_beat_t    pending_beats[$];
  track_result_t expected_tracks[$];
  int            err_count = 0;
  int            cycle = 0;

  // predictor copy of the tracker table and registers
  logic [11:0] radius_px = nbt_pkg::RadiusReset;
  logic [15:0] gain_q16 = nbt_pkg::GainReset;
  logic        live[nbt_pkg::MaxTracks];
  logic        claimed[nbt_pkg::MaxTracks];
  logic [15:0] id_of[nbt_pkg::MaxTracks];
  logic [15:0] pos_x[nbt_pkg::MaxTracks];
  logic [15:0] pos_y[nbt_pkg::MaxTracks];
  logic [23:0] sm_x[nbt_pkg::MaxTracks];
  logic [23:0] sm_y[nbt_pkg::MaxTracks];
  logic [15:0] age_of[nbt_pkg::MaxTracks];
  held_blob_t  held[nbt_pkg::MaxBlobs];
  int          held_count = 0;
  logic [15:0] id_next = '0;

  // generator memory of the previous frame, to aim blobs at live trackers
  logic [15:0] prev_x[nbt_pkg::MaxBlobs];
  logic [15:0] prev_y[nbt_pkg::MaxBlobs];
  int          prev_n = 0;

  initial begin
    for (int i = 0; i < nbt_pkg::MaxTracks; i++) begin
      live[i] = 1'b0;
      claimed[i] = 1'b0;
    end
  end

  // exponential smoothing of one axis, gain in Q0.16
  function automatic logic [23:0] smooth_step(logic [23:0] s, logic [15:0] p);
    longint unsigned acc;
    acc = longint'(s) * (65536 - longint'(gain_q16)) + (longint'(p) << 8) * longint'(gain_q16);
    return acc[39:16];
  endfunction

  function automatic longint unsigned absdiff(logic [15:0] a, logic [15:0] b);
    return (a > b) ? longint'(a - b) : longint'(b - a);
  endfunction

  // advance the predictor by one accepted beat
  task automatic track_beat(blob_beat_t b);
    longint unsigned r2, d2, bestd;
    int best;
    int fs;
    track_result_t res;
    if (b.present && held_count < nbt_pkg::MaxBlobs) begin
      r2 = longint'(radius_px) * 16 * longint'(radius_px) * 16;
      best = -1;
      bestd = 0;
      for (int j = 0; j < nbt_pkg::MaxTracks; j++) begin
        if (!live[j] || claimed[j]) continue;
        d2 = absdiff(pos_x[j], b.x) ** 2 + absdiff(pos_y[j], b.y) ** 2;
        if (d2 >= r2) continue;
        // ties go to the lower id, then the lower slot
        if (best < 0 || d2 < bestd || (d2 == bestd && id_of[j] < id_of[best])) begin
          best = j;
          bestd = d2;
        end
      end
      held[held_count] = '{b.x, b.y, 1'b0, 0};
      if (best >= 0) begin
        pos_x[best] = b.x;
        pos_y[best] = b.y;
        sm_x[best] = smooth_step(sm_x[best], b.x);
        sm_y[best] = smooth_step(sm_y[best], b.y);
        if (age_of[best] != 16'hffff) age_of[best]++;
        claimed[best] = 1'b1;
        held[held_count].matched = 1'b1;
        held[held_count].slot = best;
      end
      held_count++;
    end
    if (!b.fend) return;
    // trackers nobody claimed this frame are dropped
    for (int j = 0; j < nbt_pkg::MaxTracks; j++)
      if (live[j] && !claimed[j]) live[j] = 1'b0;
    if (held_count == 0) begin
      res = '{4'd0, nbt_pkg::OC_EMPTY, 16'd0, 24'd0, 24'd0, 16'd0, 1'b1};
      expected_tracks = {expected_tracks, res};
    end
    for (int k = 0; k < held_count; k++) begin
      res.blob_index = k[3:0];
      res.last = (k + 1 == held_count);
      if (held[k].matched) begin
        fs = held[k].slot;
        res.outcome = nbt_pkg::OC_MATCHED;
        res.track_id = id_of[fs];
        res.smooth_x = sm_x[fs];
        res.smooth_y = sm_y[fs];
        res.age_frames = age_of[fs];
      end else begin
        fs = -1;
        for (int j = nbt_pkg::MaxTracks - 1; j >= 0; j--)
          if (!live[j]) fs = j;
        res.smooth_x = {held[k].x, 8'd0};
        res.smooth_y = {held[k].y, 8'd0};
        res.age_frames = '0;
        if (fs >= 0) begin
          live[fs] = 1'b1;
          claimed[fs] = 1'b1;
          id_of[fs] = id_next;
          id_next++;
          pos_x[fs] = held[k].x;
          pos_y[fs] = held[k].y;
          sm_x[fs] = res.smooth_x;
          sm_y[fs] = res.smooth_y;
          age_of[fs] = '0;
          res.outcome = nbt_pkg::OC_NEW;
          res.track_id = id_of[fs];
        end else begin
          // table full
          res.outcome = nbt_pkg::OC_DROPPED;
          res.track_id = '0;
        end
      end
      expected_tracks = {expected_tracks, res};
    end
    for (int j = 0; j < nbt_pkg::MaxTracks; j++) claimed[j] = 1'b0;
    held_count = 0;
  endtask

  // cycle counter and watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // no idling in a calm window, otherwise about a third of cycles
  function automatic logic take_a_break();
    if (cycle > 6000 && cycle < 10000) return 1'b0;
    return $urandom_range(0, 99) < 32;
  endfunction

  // input driver: hold a beat until accepted, then maybe pause
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) track_beat('{in_blob_x, in_blob_y, in_blob_present, in_frame_end});
      if (!in_valid || in_ready) begin
        if (pending_beats.size() > 0 && !take_a_break()) begin
          in_blob_x <= pending_beats[0].x;
          in_blob_y <= pending_beats[0].y;
          in_blob_present <= pending_beats[0].present;
          in_frame_end <= pending_beats[0].fend;
          in_valid <= 1'b1;
          void'(pending_beats.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      err_count++;
    end
  endfunction

  // result monitor; one long hold-off to back the block up into its input
  int hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    track_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_tracks.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual blob %0d outcome %0d",
                   $realtime, out_blob_index, out_outcome);
          err_count++;
        end else begin
          want = expected_tracks.pop_front();
          check_field("blob_index", want.blob_index, out_blob_index);
          check_field("outcome", want.outcome, out_outcome);
          check_field("track_id", want.track_id, out_track_id);
          check_field("smooth_x", want.smooth_x, out_smooth_x);
          check_field("smooth_y", want.smooth_y, out_smooth_y);
          check_field("age_frames", want.age_frames, out_age_frames);
          check_field("last", want.last, out_last);
        end
      end
      if (!hold_done && cycle > 3000 && out_valid) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !take_a_break();
      end
    end
  end

  function automatic void queue_beat(logic [15:0] x, logic [15:0] y, logic pres, logic fend);
    pending_beats = {pending_beats, blob_beat_t'{x, y, pres, fend}};
  endfunction

  // position near a blob of the previous frame, or anywhere
  function automatic logic [31:0] pick_spot();
    int i;
    int jx, jy;
    if (prev_n > 0 && $urandom_range(0, 99) < 70) begin
      i = $urandom_range(0, prev_n - 1);
      jx = int'(prev_x[i]) + $urandom_range(0, 600) - 300;
      jy = int'(prev_y[i]) + $urandom_range(0, 600) - 300;
      if (jx < 0) jx = 0;
      if (jx > 65535) jx = 65535;
      if (jy < 0) jy = 0;
      if (jy > 65535) jy = 65535;
      return {jx[15:0], jy[15:0]};
    end
    return $urandom();
  endfunction

  // one random frame; returns the blobs it carries, at most MaxBlobs
  function automatic int queue_frame();
    int nb;
    logic [31:0] spot;
    logic [15:0] nx[nbt_pkg::MaxBlobs];
    logic [15:0] ny[nbt_pkg::MaxBlobs];
    logic bare_end;
    if ($urandom_range(0, 99) < 5) begin
      queue_beat(16'($urandom()), 16'($urandom()), 1'b0, 1'b1);
      prev_n = 0;
      return 0;
    end
    nb = ($urandom_range(0, 99) < 8) ? $urandom_range(10, 18) : $urandom_range(1, 5);
    bare_end = $urandom_range(0, 99) < 20;
    for (int k = 0; k < nb; k++) begin
      spot = pick_spot();
      if (k < nbt_pkg::MaxBlobs) begin
        nx[k] = spot[31:16];
        ny[k] = spot[15:0];
      end
      // stray beat without a blob, ignored by the block
      if ($urandom_range(0, 99) < 10)
        queue_beat(16'($urandom()), 16'($urandom()), 1'b0, 1'b0);
      queue_beat(spot[31:16], spot[15:0], 1'b1, (k == nb - 1) && !bare_end);
    end
    if (bare_end) queue_beat(16'($urandom()), 16'($urandom()), 1'b0, 1'b1);
    prev_n = (nb < nbt_pkg::MaxBlobs) ? nb : nbt_pkg::MaxBlobs;
    for (int k = 0; k < prev_n; k++) begin
      prev_x[k] = nx[k];
      prev_y[k] = ny[k];
    end
    return prev_n;
  endfunction

  // let the block drain completely before touching the registers
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_beats.size() > 0 || in_valid || expected_tracks.size() > 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(nbt_pkg::cfg_idx_t idx, logic [15:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == nbt_pkg::CFG_RADIUS) radius_px = value[11:0];
    else gain_q16 = value;
    cfg_valid <= 1'b0;
  endtask

  int blobs_sent;

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty frame, field extremes, a bare frame end
    queue_beat(16'h0000, 16'h0000, 1'b0, 1'b1);
    queue_beat(16'h0000, 16'h0000, 1'b1, 1'b0);
    queue_beat(16'hffff, 16'hffff, 1'b1, 1'b0);
    queue_beat(16'h8000, 16'h1234, 1'b1, 1'b1);
    queue_beat(16'h0000, 16'h0000, 1'b1, 1'b0);
    queue_beat(16'hffff, 16'hfff0, 1'b1, 1'b0);
    queue_beat(16'h5555, 16'haaaa, 1'b0, 1'b1);
    // tie between two trackers at the same distance
    queue_beat(16'h0000, 16'h0000, 1'b0, 1'b1);
    queue_beat(16'd1000, 16'd1000, 1'b1, 1'b0);
    queue_beat(16'd1200, 16'd1000, 1'b1, 1'b1);
    queue_beat(16'd1100, 16'd1000, 1'b1, 1'b0);
    queue_beat(16'd1100, 16'd1000, 1'b1, 1'b1);
    // more blobs than the frame buffer holds: the last ones are ignored
    for (int k = 0; k < 18; k++)
      queue_beat(16'(k * 3000), 16'(k * 211), 1'b1, k == 17);
    wait_drained();

    // register settings, extremes included, each followed by random frames
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: begin
          write_reg(nbt_pkg::CFG_RADIUS, 16'd4095);
          write_reg(nbt_pkg::CFG_GAIN, 16'hffff);
        end
        2: begin
          write_reg(nbt_pkg::CFG_RADIUS, 16'd0);
          write_reg(nbt_pkg::CFG_GAIN, 16'd0);
        end
        3: begin
          write_reg(nbt_pkg::CFG_RADIUS, 16'd40);
          write_reg(nbt_pkg::CFG_GAIN, 16'd32768);
        end
        4: begin
          write_reg(nbt_pkg::CFG_RADIUS, 16'd1);
          write_reg(nbt_pkg::CFG_GAIN, 16'd1);
        end
        5: begin
          write_reg(nbt_pkg::CFG_RADIUS, 16'($urandom_range(0, 4095)));
          write_reg(nbt_pkg::CFG_GAIN, 16'($urandom()));
        end
        default: ;
      endcase
      blobs_sent = 0;
      while (blobs_sent < 55) blobs_sent += queue_frame();
      wait_drained();
    end

    repeat (100) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
